>>> hw/rtl/pairwise_magnet_force_assert.svh
// ----------------------------------------------------------------------------
// pairwise_magnet_force assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_MAGNET_FORCE_ASSERT_SVH
`define PAIRWISE_MAGNET_FORCE_ASSERT_SVH

// same-cycle implication
`define PMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pmf_pkg.sv
// ----------------------------------------------------------------------------
// pmf_pkg
// Types, register indexes and constants of the pairwise magnet force unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pmf_pkg;

  typedef enum logic [1:0] {
    REG_OWN_STRENGTH = 2'd0,
    REG_MIN_DISTANCE = 2'd1,
    REG_MAX_FORCE    = 2'd2
  } pmf_reg_t;

  localparam logic signed [31:0] OWN_STRENGTH_RST = 32'sd0;
  localparam logic [30:0]        MIN_DISTANCE_RST = 31'd6554;
  localparam logic [30:0]        MAX_FORCE_RST    = 31'd327680;

  // distances at or below one ten-thousandth of a unit give no direction
  localparam int TINY_SCALE = 10000;

  typedef struct packed {
    logic        kill;
    logic        tiny;
    logic        ox_neg;
    logic        oy_neg;
    logic        fneg;
    logic [31:0] ax;
    logic [31:0] ay;
  } pmf_side_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pmf_in_if.sv
// ----------------------------------------------------------------------------
// pmf_in_if
// Valid/ready channel carrying one offset and target strength per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset_x;
  logic [31:0] offset_y;
  logic [31:0] target_strength;
  logic        skip_target;

  modport source (output valid, offset_x, offset_y, target_strength, skip_target,
                  input ready);
  modport sink (input valid, offset_x, offset_y, target_strength, skip_target,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pmf_out_if.sv
// ----------------------------------------------------------------------------
// pmf_out_if
// Valid/ready channel carrying one force vector per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] force_x;
  logic [31:0] force_y;
  logic        force_applied;

  modport source (output valid, force_x, force_y, force_applied, input ready);
  modport sink (input valid, force_x, force_y, force_applied, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pairwise_magnet_force.sv
// ----------------------------------------------------------------------------
// pairwise_magnet_force
// Pipelined clamped inverse-square force between a magnet and one target.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   in_if    sink       offset_x, offset_y, target_strength, skip_target
//   out_if   source     force_x, force_y, force_applied
//   cfg_*    write      own_strength, min_distance, max_force
//
// one transfer per cycle while the pipeline is not held; the 32-stage square
// root, the (31 + FRAC_BITS)-stage force quotient and the 31-stage direction
// divide each do one compare-subtract per stage.
// the whole pipeline holds while a result waits and out_if.ready is low.
// rst_n (synchronous) clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_magnet_force #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pmf_in_if.sink           in_if,
  pmf_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pmf_pkg::*;

  localparam int SQ_N = 32;
  localparam int NQ   = 31 + FRAC_BITS;
  localparam int DN   = 31;
  localparam int NST  = SQ_N + NQ + DN + 10;
  localparam logic [31:0] TINY_MAX = 32'((64'd1 << FRAC_BITS) / TINY_SCALE);

  // ---------------------------------------------------------------- config
  logic signed [31:0] own_strength_r;
  logic [30:0]        min_distance_r;
  logic [30:0]        max_force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_strength_r <= OWN_STRENGTH_RST;
      min_distance_r <= MIN_DISTANCE_RST;
      max_force_r    <= MAX_FORCE_RST;
    end else if (cfg_we) begin
      unique case (pmf_reg_t'(cfg_index))
        REG_OWN_STRENGTH: own_strength_r <= cfg_data;
        REG_MIN_DISTANCE: min_distance_r <= cfg_data[30:0];
        REG_MAX_FORCE:    max_force_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic [NST-1:0] v_r;
  logic           ce;
  logic           acc;

  assign ce          = !v_r[NST-1] || out_if.ready;
  assign acc         = in_if.valid && ce;
  assign in_if.ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[NST-2:0], acc};
    end
  end

  // ---------------------------------------------------------------- stage a
  pmf_side_t   a_side_r;
  logic [31:0] a_ms_r;
  logic [31:0] a_mt_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      a_side_r.kill   <= in_if.skip_target || (in_if.target_strength == 32'd0) ||
                         (own_strength_r == 32'sd0);
      a_side_r.tiny   <= 1'b0;
      a_side_r.ox_neg <= in_if.offset_x[31];
      a_side_r.oy_neg <= in_if.offset_y[31];
      a_side_r.fneg   <= (own_strength_r[31] == in_if.target_strength[31]);
      a_side_r.ax     <= mag32(in_if.offset_x);
      a_side_r.ay     <= mag32(in_if.offset_y);
      a_ms_r          <= mag32(own_strength_r);
      a_mt_r          <= mag32(in_if.target_strength);
    end
  end

  // ---------------------------------------------------------------- stage b
  pmf_side_t   b_side_r;
  logic [63:0] b_sx_r;
  logic [63:0] b_sy_r;
  logic [63:0] b_p_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      b_side_r <= a_side_r;
      b_sx_r   <= 64'(a_side_r.ax) * 64'(a_side_r.ax);
      b_sy_r   <= 64'(a_side_r.ay) * 64'(a_side_r.ay);
      b_p_r    <= 64'(a_ms_r) * 64'(a_mt_r);
    end
  end

  // ------------------------------------------------- stage c and square root
  logic [34:0] sq_rem_r  [SQ_N+1];
  logic [31:0] sq_root_r [SQ_N+1];
  logic [63:0] sq_s_r    [SQ_N+1];
  logic [63:0] sq_p_r    [SQ_N+1];
  pmf_side_t   sq_side_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_s_r[0]    <= b_sx_r + b_sy_r;
      sq_p_r[0]    <= b_p_r;
      sq_side_r[0] <= b_side_r;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [34:0] rs;
    logic [34:0] trial;
    logic        ge;

    always_comb begin
      rs    = {sq_rem_r[k][32:0], sq_s_r[k][63:62]};
      trial = {1'b0, sq_root_r[k], 2'b01};
      ge    = (rs >= trial);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rem_r[k+1]  <= ge ? (rs - trial) : rs;
        sq_root_r[k+1] <= {sq_root_r[k][30:0], ge};
        sq_s_r[k+1]    <= {sq_s_r[k][61:0], 2'b00};
        sq_p_r[k+1]    <= sq_p_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  end

  // ------------------------------------------------- stage d: distance clamp
  pmf_side_t   d_side_r;
  logic [31:0] d_d_r;
  logic [63:0] d_p_r;
  logic [31:0] d_d_nxt;
  pmf_side_t   d_side_nxt;

  always_comb begin
    d_d_nxt = (sq_root_r[SQ_N] < {1'b0, min_distance_r}) ? {1'b0, min_distance_r}
                                                         : sq_root_r[SQ_N];
    d_side_nxt      = sq_side_r[SQ_N];
    d_side_nxt.tiny = (d_d_nxt <= TINY_MAX);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_side_r <= d_side_nxt;
      d_d_r    <= d_d_nxt;
      d_p_r    <= sq_p_r[SQ_N];
    end
  end

  // ------------------------------------------------- stage e: distance square
  pmf_side_t   e_side_r;
  logic [31:0] e_d_r;
  logic [63:0] e_d2_r;
  logic [63:0] e_p_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      e_side_r <= d_side_r;
      e_d_r    <= d_d_r;
      e_d2_r   <= 64'(d_d_r) * 64'(d_d_r);
      e_p_r    <= d_p_r;
    end
  end

  // ------------------------------------------------- force quotient p*2^F/d2
  logic [63:0] dv_r_r   [NQ+1];
  logic [NQ-1:0] dv_num_r [NQ+1];
  logic [NQ-1:0] dv_q_r   [NQ+1];
  logic        dv_sat_r [NQ+1];
  logic [63:0] dv_d2_r  [NQ+1];
  logic [31:0] dv_d_r   [NQ+1];
  pmf_side_t   dv_side_r [NQ+1];
  logic [63:0] dv_r0;

  assign dv_r0 = {31'd0, e_p_r[63:31]};

  // quotient of 2^31 or more always saturates
  always_ff @(posedge clk) begin
    if (ce) begin
      dv_r_r[0]    <= dv_r0;
      dv_num_r[0]  <= {e_p_r[30:0], {FRAC_BITS{1'b0}}};
      dv_q_r[0]    <= '0;
      dv_sat_r[0]  <= (dv_r0 >= e_d2_r);
      dv_d2_r[0]   <= e_d2_r;
      dv_d_r[0]    <= e_d_r;
      dv_side_r[0] <= e_side_r;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_fdiv
    logic [63:0] rs;
    logic        ge;

    always_comb begin
      rs = {dv_r_r[k][62:0], dv_num_r[k][NQ-1]};
      ge = (rs >= dv_d2_r[k]);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dv_r_r[k+1]    <= ge ? (rs - dv_d2_r[k]) : rs;
        dv_num_r[k+1]  <= {dv_num_r[k][NQ-2:0], 1'b0};
        dv_q_r[k+1]    <= {dv_q_r[k][NQ-2:0], ge};
        dv_sat_r[k+1]  <= dv_sat_r[k];
        dv_d2_r[k+1]   <= dv_d2_r[k];
        dv_d_r[k+1]    <= dv_d_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // ------------------------------------------------- stage g: magnitude clamp
  pmf_side_t   g_side_r;
  logic [31:0] g_d_r;
  logic [30:0] g_q_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      g_side_r <= dv_side_r[NQ];
      g_d_r    <= dv_d_r[NQ];
      g_q_r    <= (dv_sat_r[NQ] || (dv_q_r[NQ] > NQ'(max_force_r))) ? max_force_r
                                                                     : dv_q_r[NQ][30:0];
    end
  end

  // ------------------------------------------------- stage h: offset * force
  pmf_side_t   h_side_r;
  logic [31:0] h_d_r;
  logic [63:0] h_nx_r;
  logic [63:0] h_ny_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      h_side_r <= g_side_r;
      h_d_r    <= g_d_r;
      h_nx_r   <= 64'(g_side_r.ax) * 64'(g_q_r);
      h_ny_r   <= 64'(g_side_r.ay) * 64'(g_q_r);
    end
  end

  // ------------------------------------------------- direction divide by d
  // offset never exceeds d, so the quotient fits in 31 bits
  logic [31:0] ux_r_r   [DN+1];
  logic [31:0] uy_r_r   [DN+1];
  logic [30:0] ux_num_r [DN+1];
  logic [30:0] uy_num_r [DN+1];
  logic [30:0] ux_q_r   [DN+1];
  logic [30:0] uy_q_r   [DN+1];
  logic [31:0] u_d_r    [DN+1];
  pmf_side_t   u_side_r [DN+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      ux_r_r[0]   <= h_nx_r[62:31];
      uy_r_r[0]   <= h_ny_r[62:31];
      ux_num_r[0] <= h_nx_r[30:0];
      uy_num_r[0] <= h_ny_r[30:0];
      ux_q_r[0]   <= '0;
      uy_q_r[0]   <= '0;
      u_d_r[0]    <= h_d_r;
      u_side_r[0] <= h_side_r;
    end
  end

  for (genvar k = 0; k < DN; k++) begin : g_udiv
    logic [32:0] rsx;
    logic [32:0] rsy;
    logic        gex;
    logic        gey;

    always_comb begin
      rsx = {ux_r_r[k], ux_num_r[k][30]};
      rsy = {uy_r_r[k], uy_num_r[k][30]};
      gex = (rsx >= {1'b0, u_d_r[k]});
      gey = (rsy >= {1'b0, u_d_r[k]});
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ux_r_r[k+1]   <= gex ? 32'(rsx - {1'b0, u_d_r[k]}) : rsx[31:0];
        uy_r_r[k+1]   <= gey ? 32'(rsy - {1'b0, u_d_r[k]}) : rsy[31:0];
        ux_num_r[k+1] <= {ux_num_r[k][29:0], 1'b0};
        uy_num_r[k+1] <= {uy_num_r[k][29:0], 1'b0};
        ux_q_r[k+1]   <= {ux_q_r[k][29:0], gex};
        uy_q_r[k+1]   <= {uy_q_r[k][29:0], gey};
        u_d_r[k+1]    <= u_d_r[k];
        u_side_r[k+1] <= u_side_r[k];
      end
    end
  end

  // ------------------------------------------------- output register
  pmf_side_t   o_side;
  logic        o_zero;
  logic        o_nx;
  logic        o_ny;
  logic [31:0] fx_mag;
  logic [31:0] fy_mag;
  logic [31:0] force_x_r;
  logic [31:0] force_y_r;
  logic        force_applied_r;

  always_comb begin
    o_side = u_side_r[DN];
    o_zero = o_side.kill || o_side.tiny;
    o_nx   = (o_side.ox_neg == o_side.fneg);
    o_ny   = (o_side.oy_neg == o_side.fneg);
    fx_mag = {1'b0, ux_q_r[DN]};
    fy_mag = {1'b0, uy_q_r[DN]};
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      force_x_r       <= o_zero ? '0 : (o_nx ? (~fx_mag + 32'd1) : fx_mag);
      force_y_r       <= o_zero ? '0 : (o_ny ? (~fy_mag + 32'd1) : fy_mag);
      force_applied_r <= !o_side.kill;
    end
  end

  assign out_if.valid         = v_r[NST-1];
  assign out_if.force_x       = force_x_r;
  assign out_if.force_y       = force_y_r;
  assign out_if.force_applied = force_applied_r;

  // ------------------------------------------------- assertions
`include "pairwise_magnet_force_assert.svh"

  `PMF_ASSERT_IMP(a_no_force_zero, out_if.valid && !out_if.force_applied, out_if.force_x == 32'd0 && out_if.force_y == 32'd0, "force without applied flag")
  `PMF_ASSERT_NXT(a_accept_enters, in_if.valid && in_if.ready, v_r[0], "accepted item not in first stage")
  `PMF_ASSERT_NXT(a_stall_freezes, out_if.valid && !out_if.ready, v_r == $past(v_r), "pipeline moved during stall")
  `PMF_ASSERT_IMP(a_ready_only_stall, !in_if.ready, out_if.valid && !out_if.ready, "input held off without a stall")

endmodule

`default_nettype wire

>>> test/pmf_tb_if.sv
// ----------------------------------------------------------------------------
// pmf_tb_if
// Testbench types for queued input pairs and expected force results.
// ----------------------------------------------------------------------------
package pmf_tb_pkg;
  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic        applied;
  } force_t;
  typedef struct {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] ts;
    logic        skip;
  } pair_t;
endpackage

>>> test/tb_pairwise_magnet_force.sv
// ----------------------------------------------------------------------------
// tb_pairwise_magnet_force
// Streams offset/strength pairs through the force unit under several register
// settings and idle patterns, and checks each force against a local model.
// ----------------------------------------------------------------------------
module tb_pairwise_magnet_force;
  timeunit 1ns;
  timeprecision 1ps;
  import pmf_pkg::*;
  import pmf_tb_pkg::*;

  localparam int LATENCY = 120;
  localparam int WATCHDOG = 20000;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pmf_in_if in_if ();
  pmf_out_if out_if ();

  pairwise_magnet_force dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copy for the predictor
  logic [31:0] magnet_str = OWN_STRENGTH_RST;
  logic [30:0] dist_floor = MIN_DISTANCE_RST;
  logic [30:0] force_cap = MAX_FORCE_RST;

  pair_t pending_pairs[$];
  force_t expected_forces[$];
  int send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
  int errors = 0, idle_cycles = 0;
  bit in_taken = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic force_t predict_force(pair_t p);
    force_t f;
    logic [63:0] ax, ay, d, d2, prod, q, r, mx, my;
    logic fneg, nx, ny;
    f.fx = 0; f.fy = 0; f.applied = 0;
    if (p.skip || p.ts == 0 || magnet_str == 0) return f;
    ax = {32'd0, mag32(p.ox)};
    ay = {32'd0, mag32(p.oy)};
    d = isqrt(ax * ax + ay * ay);
    if (d < {33'd0, dist_floor}) d = {33'd0, dist_floor};
    f.applied = 1;
    if (d * 10000 <= 64'd65536) return f;
    prod = {32'd0, mag32(magnet_str)} * {32'd0, mag32(p.ts)};
    fneg = magnet_str[31] == p.ts[31];
    d2 = d * d;
    q = prod / d2;
    r = prod % d2;
    if (q > force_cap) begin
      q = force_cap;
    end else begin
      for (int i = 0; i < 16; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= d2) begin
          r -= d2;
          q |= 1;
        end
        if (q > force_cap) begin
          q = force_cap;
          break;
        end
      end
    end
    mx = (ax * q) / d;
    my = (ay * q) / d;
    nx = !(p.ox[31] != fneg);
    ny = !(p.oy[31] != fneg);
    if (mx > 64'h7FFFFFFF) mx = 64'h7FFFFFFF;
    if (my > 64'h7FFFFFFF) my = 64'h7FFFFFFF;
    f.fx = nx ? -mx[31:0] : mx[31:0];
    f.fy = ny ? -my[31:0] : my[31:0];
    return f;
  endfunction

  // driver: offers pending pairs, holds an offered pair until its transfer
  initial begin
    in_if.valid = 0;
    in_if.offset_x = 0; in_if.offset_y = 0;
    in_if.target_strength = 0; in_if.skip_target = 0;
  end
  always @(negedge clk) begin
    if (rst_n && !(in_if.valid && !in_taken)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1;
        in_if.offset_x <= pending_pairs[0].ox;
        in_if.offset_y <= pending_pairs[0].oy;
        in_if.target_strength <= pending_pairs[0].ts;
        in_if.skip_target <= pending_pairs[0].skip;
      end else begin
        in_if.valid <= 0;
      end
    end
  end

  // predict on each input transfer
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      expected_forces.push_back(predict_force('{in_if.offset_x, in_if.offset_y,
                                                 in_if.target_strength,
                                                 in_if.skip_target}));
      void'(pending_pairs.pop_front());
    end
  end

  // receiver stall pattern, with an optional long hold-off
  initial out_if.ready = 0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_forces.size() == 0) begin
          $error("force result with nothing expected");
          errors++;
        end else begin
          force_t e;
          e = expected_forces.pop_front();
          if (out_if.force_x !== e.fx) begin
            $error("force_x expected %h got %h", e.fx, out_if.force_x);
            errors++;
          end
          if (out_if.force_y !== e.fy) begin
            $error("force_y expected %h got %h", e.fy, out_if.force_y);
            errors++;
          end
          if (out_if.force_applied !== e.applied) begin
            $error("force_applied expected %b got %b", e.applied,
                   out_if.force_applied);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(pmf_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_OWN_STRENGTH: magnet_str = val;
      REG_MIN_DISTANCE: dist_floor = val[30:0];
      default: force_cap = val[30:0];
    endcase
  endtask

  task automatic drain;
    wait (pending_pairs.size() == 0 && expected_forces.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom_range(255) - 128;
      3: return $urandom;
      default: return ($urandom_range(1) ? -1 : 1) * $urandom_range(32'h0040_0000);
    endcase
  endfunction

  task automatic queue_pair(logic [31:0] ox, logic [31:0] oy, logic [31:0] ts,
                            logic skip);
    pending_pairs.push_back('{ox, oy, ts, skip});
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++)
      queue_pair(rand_word(), rand_word(),
                 ($urandom_range(15) == 0) ? 32'd0 : rand_word(),
                 $urandom_range(9) == 0);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: zero own strength first, then extremes and special cases
    queue_pair(32'h10000, 0, 32'h10000, 0);
    drain();
    write_reg(REG_OWN_STRENGTH, 32'h0001_0000);
    queue_pair(32'h10000, 32'h10000, 32'h10000, 0);
    queue_pair(32'h10000, 0, 32'h10000, 1);
    queue_pair(32'h10000, 0, 32'd0, 0);
    queue_pair(0, 0, 32'h10000, 0);
    queue_pair(32'h80000000, 32'h80000000, 32'h80000000, 0);
    queue_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    queue_pair(32'hFFFF0000, 32'h00030000, 32'hFFFE0000, 0);
    queue_pair(32'h00001000, 32'hFFFFF000, 32'h7FFFFFFF, 0);
    drain();
    write_reg(REG_MIN_DISTANCE, 32'd0);
    queue_pair(0, 0, 32'h10000, 0);
    queue_pair(32'd3, 32'd4, 32'h10000, 0);
    queue_pair(32'd7, 32'd0, 32'h10000, 0);
    drain();
    write_reg(REG_MAX_FORCE, 32'h7FFFFFFF);
    write_reg(REG_OWN_STRENGTH, 32'h80000000);
    queue_pair(32'd100, 32'hFFFFFF00, 32'h80000000, 0);
    queue_pair(32'h00010000, 32'h00010000, 32'h7FFFFFFF, 0);
    drain();
    // random phases over several register settings and idle patterns
    write_reg(REG_MIN_DISTANCE, 32'(MIN_DISTANCE_RST));
    write_reg(REG_MAX_FORCE, 32'(MAX_FORCE_RST));
    write_reg(REG_OWN_STRENGTH, 32'h0002_8000);
    random_phase(250, 0, 0);
    write_reg(REG_OWN_STRENGTH, 32'hFFF0_0000);
    write_reg(REG_MAX_FORCE, 32'd0);
    random_phase(150, 50, 0);
    write_reg(REG_OWN_STRENGTH, 32'h7FFFFFFF);
    write_reg(REG_MAX_FORCE, 32'h7FFFFFFF);
    write_reg(REG_MIN_DISTANCE, 32'h7FFFFFFF);
    random_phase(150, 0, 50);
    write_reg(REG_MIN_DISTANCE, 32'd5);
    write_reg(REG_OWN_STRENGTH, $urandom);
    random_phase(200, 38, 38);
    // long receiver hold-off while the sender keeps offering transfers
    write_reg(REG_MIN_DISTANCE, 32'd6);
    hold_off = 400;
    random_phase(200, 0, 0);
    write_reg(REG_OWN_STRENGTH, 32'h80000000);
    write_reg(REG_MAX_FORCE, 32'(MAX_FORCE_RST));
    random_phase(150, 20, 20);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pmf_pkg.sv
hw/rtl/pmf_in_if.sv
hw/rtl/pmf_out_if.sv
hw/rtl/pairwise_magnet_force.sv
test/pmf_tb_if.sv
test/tb_pairwise_magnet_force.sv
